>>> hw/rtl/lob_pkg.sv
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and constants for the logo overlay alpha blend block.
// ----------------------------------------------------------------------------
package lob_pkg;

    // Largest frame or logo dimension after clamping
    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int ORG_W   = 14;
    localparam int SGN_W   = 15;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGO_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGO_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_POS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY      = 3'd7;

    // Anchor codes, row order top-left to bottom-right, then explicit point
    localparam logic [3:0] ANCHOR_TL    = 4'd0;
    localparam logic [3:0] ANCHOR_TC    = 4'd1;
    localparam logic [3:0] ANCHOR_TR    = 4'd2;
    localparam logic [3:0] ANCHOR_CL    = 4'd3;
    localparam logic [3:0] ANCHOR_C     = 4'd4;
    localparam logic [3:0] ANCHOR_CR    = 4'd5;
    localparam logic [3:0] ANCHOR_BL    = 4'd6;
    localparam logic [3:0] ANCHOR_BC    = 4'd7;
    localparam logic [3:0] ANCHOR_BR    = 4'd8;
    localparam logic [3:0] ANCHOR_POINT = 4'd9;

    // Placement selectors for one axis
    localparam logic [1:0] SEL_NEAR   = 2'd0;
    localparam logic [1:0] SEL_CENTER = 2'd1;
    localparam logic [1:0] SEL_FAR    = 2'd2;

    // Item kinds
    localparam logic KIND_LOGO  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    localparam logic [6:0] OPACITY_FULL = 7'd100;
    localparam logic [7:0] ALPHA_FULL   = 8'd255;

    // Reciprocal constants: x/100 for x < 25600, n/255 for n <= 65025
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_100_SH = 19;
    localparam logic [15:0] RECIP_255   = 16'd32897;
    localparam int          RECIP_255_SH = 23;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PLACE,
        ST_POS,
        ST_ADDR,
        ST_READ,
        ST_FETCH,
        ST_SCALE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic write_logo;
        logic place;
        logic pos;
        logic addr;
        logic read;
        logic fetch;
        logic scale;
        logic mul;
        logic div;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic kind;
        logic frame_start;
        logic blend_go;
        logic addr_ok;
        logic out_free;
    } ctrl_status_t;

    // Clamp a dimension to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > DIM_W'(MAX_DIM))
            begin
                r = DIM_W'(MAX_DIM);
            end
            return r;
        end
    endfunction

endpackage

>>> hw/rtl/lob_ram.sv
// ----------------------------------------------------------------------------
// lob_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read on one port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lob_ctrl.sv
// ----------------------------------------------------------------------------
// lob_ctrl
// Sequencer that walks one item at a time through the overlay datapath.
// ----------------------------------------------------------------------------
module lob_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lob_pkg::ctrl_status_t status,
    output lob_pkg::ctrl_cmd_t    cmd
);

    lob_pkg::state_t state_reg;
    lob_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lob_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lob_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lob_pkg::ST_DISPATCH;
                end
            end
            lob_pkg::ST_DISPATCH:
            begin
                if (status.kind == lob_pkg::KIND_LOGO)
                begin
                    state_next = lob_pkg::ST_IDLE;
                end
                else if (status.frame_start)
                begin
                    state_next = lob_pkg::ST_PLACE;
                end
                else
                begin
                    state_next = lob_pkg::ST_POS;
                end
            end
            lob_pkg::ST_PLACE: state_next = lob_pkg::ST_POS;
            lob_pkg::ST_POS:
            begin
                state_next = status.blend_go ? lob_pkg::ST_ADDR : lob_pkg::ST_DONE;
            end
            lob_pkg::ST_ADDR: state_next = lob_pkg::ST_READ;
            lob_pkg::ST_READ:
            begin
                state_next = status.addr_ok ? lob_pkg::ST_FETCH : lob_pkg::ST_DONE;
            end
            lob_pkg::ST_FETCH: state_next = lob_pkg::ST_SCALE;
            lob_pkg::ST_SCALE: state_next = lob_pkg::ST_MUL;
            lob_pkg::ST_MUL:   state_next = lob_pkg::ST_DIV;
            lob_pkg::ST_DIV:   state_next = lob_pkg::ST_DONE;
            lob_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = lob_pkg::ST_IDLE;
                end
            end
            default: state_next = lob_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            lob_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.latch_in = in_valid;
            end
            lob_pkg::ST_DISPATCH: cmd.write_logo = (status.kind == lob_pkg::KIND_LOGO);
            lob_pkg::ST_PLACE:    cmd.place = 1'b1;
            lob_pkg::ST_POS:      cmd.pos   = 1'b1;
            lob_pkg::ST_ADDR:     cmd.addr  = 1'b1;
            lob_pkg::ST_READ:     cmd.read  = status.addr_ok;
            lob_pkg::ST_FETCH:    cmd.fetch = 1'b1;
            lob_pkg::ST_SCALE:    cmd.scale = 1'b1;
            lob_pkg::ST_MUL:      cmd.mul   = 1'b1;
            lob_pkg::ST_DIV:      cmd.div   = 1'b1;
            lob_pkg::ST_DONE:     cmd.load_out = status.out_free;
            default:              cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/lob_datapath.sv
// ----------------------------------------------------------------------------
// lob_datapath
// Config registers, raster counters, placement, logo store and blend math.
// ----------------------------------------------------------------------------
module lob_datapath #(
    parameter int LOGO_PIXELS = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [lob_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lob_pkg::CFG_W-1:0]         cfg_data,
    // input item
    input  logic                              kind,
    input  logic [15:0]                       logo_index,
    input  logic [7:0]                        red,
    input  logic [7:0]                        green,
    input  logic [7:0]                        blue,
    input  logic [7:0]                        alpha,
    input  logic                              frame_start,
    // result item
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_red,
    output logic [7:0]                        out_green,
    output logic [7:0]                        out_blue,
    output logic                              misfit,
    output logic                              frame_end,
    // controller link
    input  lob_pkg::ctrl_cmd_t                cmd,
    output lob_pkg::ctrl_status_t             status
);

    localparam int ADDR_W = (LOGO_PIXELS > 1) ? $clog2(LOGO_PIXELS) : 1;
    localparam int LI_W   = 25;

    // Configuration registers
    logic [lob_pkg::DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic [lob_pkg::DIM_W-1:0] logo_width_reg, logo_height_reg;
    logic [3:0]                anchor_mode_reg;
    logic [11:0]               margin_reg;
    logic [23:0]               point_pos_reg;
    logic [6:0]                opacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 13'd1920;
            frame_height_reg <= 13'd1080;
            logo_width_reg   <= 13'd1;
            logo_height_reg  <= 13'd1;
            anchor_mode_reg  <= lob_pkg::ANCHOR_BR;
            margin_reg       <= 12'd0;
            point_pos_reg    <= 24'd0;
            opacity_reg      <= lob_pkg::OPACITY_FULL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lob_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[12:0];
                lob_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[12:0];
                lob_pkg::CFG_LOGO_WIDTH:   logo_width_reg   <= cfg_data[12:0];
                lob_pkg::CFG_LOGO_HEIGHT:  logo_height_reg  <= cfg_data[12:0];
                lob_pkg::CFG_ANCHOR_MODE:  anchor_mode_reg  <= cfg_data[3:0];
                lob_pkg::CFG_MARGIN:       margin_reg       <= cfg_data[11:0];
                lob_pkg::CFG_POINT_POS:    point_pos_reg    <= cfg_data[23:0];
                lob_pkg::CFG_OPACITY:      opacity_reg      <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Input item latch
    logic        kind_reg, fs_reg;
    logic [15:0] idx_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg  <= kind;
            fs_reg    <= frame_start;
            idx_reg   <= logo_index;
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            alpha_reg <= alpha;
        end
    end

    // Clamped sizes, read live
    logic [lob_pkg::DIM_W-1:0] fw, fh, lw, lh;
    assign fw = lob_pkg::clamp_dim(frame_width_reg);
    assign fh = lob_pkg::clamp_dim(frame_height_reg);
    assign lw = lob_pkg::clamp_dim(logo_width_reg);
    assign lh = lob_pkg::clamp_dim(logo_height_reg);

    logic signed [lob_pkg::SGN_W-1:0] fw_s, fh_s, lw_s, lh_s, m_s;
    assign fw_s = $signed({2'b00, fw});
    assign fh_s = $signed({2'b00, fh});
    assign lw_s = $signed({2'b00, lw});
    assign lh_s = $signed({2'b00, lh});
    assign m_s  = $signed({3'b000, margin_reg});

    // Placement: anchor decode
    logic [1:0] col_sel, row_sel;
    logic       use_point;

    always_comb
    begin
        col_sel   = lob_pkg::SEL_FAR;
        row_sel   = lob_pkg::SEL_FAR;
        use_point = 1'b0;
        unique case (anchor_mode_reg)
            lob_pkg::ANCHOR_TL: begin col_sel = lob_pkg::SEL_NEAR;   row_sel = lob_pkg::SEL_NEAR;   end
            lob_pkg::ANCHOR_TC: begin col_sel = lob_pkg::SEL_CENTER; row_sel = lob_pkg::SEL_NEAR;   end
            lob_pkg::ANCHOR_TR: begin col_sel = lob_pkg::SEL_FAR;    row_sel = lob_pkg::SEL_NEAR;   end
            lob_pkg::ANCHOR_CL: begin col_sel = lob_pkg::SEL_NEAR;   row_sel = lob_pkg::SEL_CENTER; end
            lob_pkg::ANCHOR_C:  begin col_sel = lob_pkg::SEL_CENTER; row_sel = lob_pkg::SEL_CENTER; end
            lob_pkg::ANCHOR_CR: begin col_sel = lob_pkg::SEL_FAR;    row_sel = lob_pkg::SEL_CENTER; end
            lob_pkg::ANCHOR_BL: begin col_sel = lob_pkg::SEL_NEAR;   row_sel = lob_pkg::SEL_FAR;    end
            lob_pkg::ANCHOR_BC: begin col_sel = lob_pkg::SEL_CENTER; row_sel = lob_pkg::SEL_FAR;    end
            lob_pkg::ANCHOR_BR: begin col_sel = lob_pkg::SEL_FAR;    row_sel = lob_pkg::SEL_FAR;    end
            lob_pkg::ANCHOR_POINT: use_point = 1'b1;
            // unknown modes act as bottom-right
            default: begin col_sel = lob_pkg::SEL_FAR; row_sel = lob_pkg::SEL_FAR; end
        endcase
    end

    // Placement: origin and fit check, halves truncate toward zero
    logic signed [lob_pkg::SGN_W-1:0] diff_x, diff_y, half_x, half_y;
    logic signed [lob_pkg::SGN_W-1:0] place_x, place_y;
    logic [2*lob_pkg::DIM_W-1:0]      logo_area;
    logic                             place_misfit;

    assign diff_x = fw_s - lw_s;
    assign diff_y = fh_s - lh_s;
    assign half_x = (diff_x + $signed({{(lob_pkg::SGN_W-1){1'b0}}, diff_x[lob_pkg::SGN_W-1]})) >>> 1;
    assign half_y = (diff_y + $signed({{(lob_pkg::SGN_W-1){1'b0}}, diff_y[lob_pkg::SGN_W-1]})) >>> 1;
    assign logo_area = lw * lh;

    always_comb
    begin
        if (use_point)
        begin
            place_x = $signed({3'b000, point_pos_reg[11:0]});
            place_y = $signed({3'b000, point_pos_reg[23:12]});
        end
        else
        begin
            unique case (col_sel)
                lob_pkg::SEL_NEAR:   place_x = m_s;
                lob_pkg::SEL_CENTER: place_x = half_x;
                default:             place_x = diff_x - m_s;
            endcase
            unique case (row_sel)
                lob_pkg::SEL_NEAR:   place_y = m_s;
                lob_pkg::SEL_CENTER: place_y = half_y;
                default:             place_y = diff_y - m_s;
            endcase
        end
        place_misfit = place_x[lob_pkg::SGN_W-1] || place_y[lob_pkg::SGN_W-1]
                    || (place_x + lw_s > fw_s) || (place_y + lh_s > fh_s)
                    || (32'(logo_area) > 32'(LOGO_PIXELS));
    end

    logic signed [lob_pkg::ORG_W-1:0] origin_x_reg, origin_y_reg;
    logic                             misfit_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            misfit_flag_reg <= 1'b0;
        end
        else if (cmd.place)
        begin
            origin_x_reg    <= place_x[lob_pkg::ORG_W-1:0];
            origin_y_reg    <= place_y[lob_pkg::ORG_W-1:0];
            misfit_flag_reg <= place_misfit;
        end
    end

    // Raster position: frame start, wrap, advance
    logic [lob_pkg::POS_W-1:0] column_count_reg, row_count_reg;
    logic [lob_pkg::POS_W-1:0] col_base, row_base, cur_col, cur_row;
    logic [lob_pkg::POS_W-1:0] column_count_next, row_count_next;
    logic [lob_pkg::DIM_W-1:0] col_inc, row_inc;
    logic                      pix_last;

    always_comb
    begin
        col_base = fs_reg ? '0 : column_count_reg;
        row_base = fs_reg ? '0 : row_count_reg;
        if (({1'b0, col_base} >= fw) || ({1'b0, row_base} >= fh))
        begin
            cur_col = '0;
            cur_row = '0;
        end
        else
        begin
            cur_col = col_base;
            cur_row = row_base;
        end
        pix_last = ({1'b0, cur_col} == fw - 13'd1) && ({1'b0, cur_row} == fh - 13'd1);
        col_inc  = {1'b0, cur_col} + 13'd1;
        row_inc  = {1'b0, cur_row} + 13'd1;
        column_count_next = col_inc[lob_pkg::POS_W-1:0];
        row_count_next    = cur_row;
        if (col_inc >= fw)
        begin
            column_count_next = '0;
            row_count_next    = (row_inc >= fh) ? '0 : row_inc[lob_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (cmd.pos)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // Logo hit test
    logic [6:0]                       op_eff;
    logic                             op_nz;
    logic signed [lob_pkg::SGN_W-1:0] dx, dy;
    logic                             in_logo;

    assign op_eff = (opacity_reg > lob_pkg::OPACITY_FULL) ? lob_pkg::OPACITY_FULL : opacity_reg;
    assign op_nz  = (op_eff != '0);
    assign dx = $signed({3'b000, cur_col}) - $signed({origin_x_reg[lob_pkg::ORG_W-1], origin_x_reg});
    assign dy = $signed({3'b000, cur_row}) - $signed({origin_y_reg[lob_pkg::ORG_W-1], origin_y_reg});
    assign in_logo = !dx[lob_pkg::SGN_W-1] && !dy[lob_pkg::SGN_W-1]
                  && (dx < lw_s) && (dy < lh_s);

    // Per-pixel registers
    logic [lob_pkg::POS_W-1:0] dx_reg, dy_reg;
    logic [6:0]                op_reg;
    logic                      mis_pix_reg, last_pix_reg;
    logic [2:0][7:0]           res_reg;
    logic [LI_W-1:0]           li_reg;
    logic [14:0]               al_prod_reg;
    logic [2:0][7:0]           logo_ch_reg;
    logic [7:0]                sa_reg;
    logic [2:0][15:0]          mix_reg;
    logic [7:0]                da;
    logic [27:0]               sa_full;
    logic [2:0][16:0]          mix_sum;
    logic [2:0][31:0]          quot_full;
    logic [31:0]               li_ext, idx_ext;
    logic [31:0]               logo_word;

    assign li_ext  = 32'(li_reg);
    assign idx_ext = 32'(idx_reg);
    assign sa_full = 28'(al_prod_reg) * 28'(lob_pkg::RECIP_100);
    assign da      = lob_pkg::ALPHA_FULL - sa_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mix_sum[i]   = 17'(logo_ch_reg[i]) * 17'(sa_reg) + 17'(res_reg[i]) * 17'(da);
            quot_full[i] = 32'(mix_reg[i]) * 32'(lob_pkg::RECIP_255);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos)
        begin
            dx_reg       <= dx[lob_pkg::POS_W-1:0];
            dy_reg       <= dy[lob_pkg::POS_W-1:0];
            op_reg       <= op_eff;
            mis_pix_reg  <= op_nz && misfit_flag_reg;
            last_pix_reg <= pix_last;
            res_reg      <= {blue_reg, green_reg, red_reg};
        end
        if (cmd.addr)
        begin
            li_reg <= LI_W'(dy_reg) * LI_W'(lw) + LI_W'(dx_reg);
        end
        if (cmd.fetch)
        begin
            al_prod_reg <= 15'(logo_word[7:0]) * 15'(op_reg);
            logo_ch_reg <= {logo_word[15:8], logo_word[23:16], logo_word[31:24]};
        end
        if (cmd.scale)
        begin
            sa_reg <= 8'(sa_full >> lob_pkg::RECIP_100_SH);
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mix_reg[i] <= mix_sum[i][15:0];
            end
        end
        if (cmd.div)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= 8'(quot_full[i] >> lob_pkg::RECIP_255_SH);
            end
        end
    end

    // Logo store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;

    assign ram_we   = cmd.write_logo && (idx_ext < 32'(LOGO_PIXELS));
    assign ram_addr = cmd.read ? li_ext[ADDR_W-1:0] : idx_ext[ADDR_W-1:0];

    lob_ram #(
        .WIDTH (32),
        .DEPTH (LOGO_PIXELS)
    ) u_logo_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.read),
        .addr  (ram_addr),
        .wdata ({red_reg, green_reg, blue_reg, alpha_reg}),
        .rdata (logo_word)
    );

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_red_reg, out_green_reg, out_blue_reg;
    logic       out_misfit_reg, out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_red_reg    <= res_reg[0];
            out_green_reg  <= res_reg[1];
            out_blue_reg   <= res_reg[2];
            out_misfit_reg <= mis_pix_reg;
            out_end_reg    <= last_pix_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign misfit    = out_misfit_reg;
    assign frame_end = out_end_reg;

    // Status to controller
    assign status.kind        = kind_reg;
    assign status.frame_start = fs_reg;
    assign status.blend_go    = op_nz && !misfit_flag_reg && in_logo;
    assign status.addr_ok     = (li_ext < 32'(LOGO_PIXELS));
    assign status.out_free    = !out_valid_reg || !out_stall;

endmodule

>>> hw/rtl/logo_overlay_alpha_blend.sv
// ----------------------------------------------------------------------------
// logo_overlay_alpha_blend
// Blends a stored RGBA logo over a raster stream of RGB frame pixels.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ---------------------------------
//  in       sink       in_valid / in_stall    kind logo_index red green blue
//                                             alpha frame_start
//  out      source     out_valid / out_stall  out_red out_green out_blue
//                                             misfit frame_end
//  cfg      sink       cfg_we                 cfg_index cfg_data
//
//  A logo write passes idle and dispatch. A frame pixel outside the logo passes
//  idle, dispatch, pos and done; inside it adds addr, read, fetch, scale, mul and
//  div; frame_start adds place. The sequencer walks each pixel through the
//  single-port logo RAM read and the blend multiply stages one at a time.
//  Reset clears control, raster counters and origin; the logo RAM is not cleared.
//  A result waits in the output register under out_stall while the next item
//  is taken; the sequencer holds only if a second result is ready first.
// ----------------------------------------------------------------------------
module logo_overlay_alpha_blend #(
    parameter int LOGO_PIXELS = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [lob_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lob_pkg::CFG_W-1:0]     cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [15:0]                   logo_index,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    alpha,
    input  logic                          frame_start,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    out_red,
    output logic [7:0]                    out_green,
    output logic [7:0]                    out_blue,
    output logic                          misfit,
    output logic                          frame_end
);

    lob_pkg::ctrl_cmd_t    cmd;
    lob_pkg::ctrl_status_t status;

    // Sequencer
    lob_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    lob_datapath #(
        .LOGO_PIXELS (LOGO_PIXELS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .logo_index  (logo_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .misfit      (misfit),
        .frame_end   (frame_end),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
